// ----- hdl/rq2y_pkg.sv -----
// ----------------------------------------------------------------------------
// rq2y_pkg: shared types, coefficients and arithmetic
// Pixel types and the BT.601 fixed-point conversion used by the quad
// RGB to YCbCr 4:2:0 converter and its interfaces.
// ----------------------------------------------------------------------------
package rq2y_pkg;

    localparam int unsigned ChanW  = 8;
    localparam int unsigned LumaW  = 24;
    localparam int unsigned ChromW = 27;
    localparam int unsigned Pixels = 4;

    typedef logic [ChanW-1:0] chan_t;

    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
    } pixel_t;

    typedef struct packed {
        chan_t luma;
        chan_t cb;
        chan_t cr;
    } ycc_t;

    // Luma coefficients, scaled by 2^16, with the offset of 16 folded in.
    localparam logic [LumaW-1:0] LumaRed    = LumaW'(16829);
    localparam logic [LumaW-1:0] LumaGreen  = LumaW'(33039);
    localparam logic [LumaW-1:0] LumaBlue   = LumaW'(6416);
    localparam logic [LumaW-1:0] LumaOffset = LumaW'((256 * 256) * 16);

    // Chroma coefficient magnitudes, scaled by 2^17, with the offset of 128.
    localparam logic [ChromW-1:0] CbRed        = ChromW'(19428);
    localparam logic [ChromW-1:0] CbGreen      = ChromW'(38141);
    localparam logic [ChromW-1:0] CbBlue       = ChromW'(57569);
    localparam logic [ChromW-1:0] CrRed        = ChromW'(57569);
    localparam logic [ChromW-1:0] CrGreen      = ChromW'(48207);
    localparam logic [ChromW-1:0] CrBlue       = ChromW'(9362);
    localparam logic [ChromW-1:0] ChromaOffset = ChromW'((512 * 256) * 128);

    // Every sum stays positive for 8-bit inputs, so the shifts are plain floors.
    function automatic chan_t luma_of(pixel_t p);
        logic [LumaW-1:0] s;
        s = LumaRed * {16'd0, p.red} + LumaGreen * {16'd0, p.green}
          + LumaBlue * {16'd0, p.blue} + LumaOffset;
        return s[23:16];
    endfunction

    function automatic chan_t cb_of(pixel_t p);
        logic [ChromW-1:0] s;
        s = ChromaOffset + CbBlue * {19'd0, p.blue}
          - CbRed * {19'd0, p.red} - CbGreen * {19'd0, p.green};
        return s[24:17];
    endfunction

    function automatic chan_t cr_of(pixel_t p);
        logic [ChromW-1:0] s;
        s = ChromaOffset + CrRed * {19'd0, p.red}
          - CrGreen * {19'd0, p.green} - CrBlue * {19'd0, p.blue};
        return s[24:17];
    endfunction

endpackage

// ----- hdl/rq2y_if.sv -----
// ----------------------------------------------------------------------------
// rq2y_if: request channels of the quad converter
// One interface for the RGB quad and one for the YCbCr 4:2:0 result.
// ----------------------------------------------------------------------------
interface rq2y_quad_if;
    logic               valid;
    logic               ready;
    rq2y_pkg::chan_t    red_top_left;
    rq2y_pkg::chan_t    green_top_left;
    rq2y_pkg::chan_t    blue_top_left;
    rq2y_pkg::chan_t    red_top_right;
    rq2y_pkg::chan_t    green_top_right;
    rq2y_pkg::chan_t    blue_top_right;
    rq2y_pkg::chan_t    red_bottom_left;
    rq2y_pkg::chan_t    green_bottom_left;
    rq2y_pkg::chan_t    blue_bottom_left;
    rq2y_pkg::chan_t    red_bottom_right;
    rq2y_pkg::chan_t    green_bottom_right;
    rq2y_pkg::chan_t    blue_bottom_right;

    modport source (
        output valid,
        output red_top_left, green_top_left, blue_top_left,
        output red_top_right, green_top_right, blue_top_right,
        output red_bottom_left, green_bottom_left, blue_bottom_left,
        output red_bottom_right, green_bottom_right, blue_bottom_right,
        input  ready
    );

    modport sink (
        input  valid,
        input  red_top_left, green_top_left, blue_top_left,
        input  red_top_right, green_top_right, blue_top_right,
        input  red_bottom_left, green_bottom_left, blue_bottom_left,
        input  red_bottom_right, green_bottom_right, blue_bottom_right,
        output ready
    );
endinterface

interface rq2y_result_if;
    logic               valid;
    logic               ready;
    rq2y_pkg::chan_t    luma_top_left;
    rq2y_pkg::chan_t    luma_top_right;
    rq2y_pkg::chan_t    luma_bottom_left;
    rq2y_pkg::chan_t    luma_bottom_right;
    rq2y_pkg::chan_t    blue_chroma;
    rq2y_pkg::chan_t    red_chroma;

    modport source (
        output valid,
        output luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
        output blue_chroma, red_chroma,
        input  ready
    );

    modport sink (
        input  valid,
        input  luma_top_left, luma_top_right, luma_bottom_left, luma_bottom_right,
        input  blue_chroma, red_chroma,
        output ready
    );
endinterface

// ----- hdl/rgb_quad_to_ycbcr420_core.sv -----
// ----------------------------------------------------------------------------
// rgb_quad_to_ycbcr420_core: 2x2 RGB quad to BT.601 YCbCr 4:2:0
// Converts each quad to four luma values and one shared Cb and Cr pair.
// ----------------------------------------------------------------------------
// The quad channel takes one 2x2 block of 8-bit RGB pixels per request; the
// result channel returns the four luma samples and the floor mean of the
// four per-pixel Cb and Cr samples.
// The datapath is three register stages: the input register, the per-pixel
// conversion register and the result register holding the chroma means.
// A quad accepted into the input register moves through the conversion
// register to the result register, where its result is presented; one quad
// is accepted every cycle while the result channel keeps taking requests.
// Each stage has its own ready, so bubbles are filled when the receiver
// stalls: up to three quads are held before quad ready falls, and it rises
// again in the same cycle that the receiver takes a result.
// Reset clears the stage valid flags only; the pipeline is empty afterwards
// and nothing else needs initialising.
// ----------------------------------------------------------------------------
module rgb_quad_to_ycbcr420_core (
    input  logic           clk,
    input  logic           rst_n,
    rq2y_quad_if.sink      quad,
    rq2y_result_if.source  result
);

    rq2y_pkg::pixel_t  in_reg   [rq2y_pkg::Pixels];
    rq2y_pkg::pixel_t  in_next  [rq2y_pkg::Pixels];
    rq2y_pkg::ycc_t    pix_reg  [rq2y_pkg::Pixels];
    logic              in_valid_reg;
    logic              pix_valid_reg;
    logic              out_valid_reg;
    logic              in_ready;
    logic              pix_ready;
    logic              out_ready;
    rq2y_pkg::chan_t   luma_reg [rq2y_pkg::Pixels];
    rq2y_pkg::chan_t   cb_reg;
    rq2y_pkg::chan_t   cr_reg;
    logic [9:0]        cb_sum;
    logic [9:0]        cr_sum;

    assign out_ready = !out_valid_reg || result.ready;
    assign pix_ready = !pix_valid_reg || out_ready;
    assign in_ready  = !in_valid_reg  || pix_ready;
    assign quad.ready = in_ready;

    always_comb
    begin
        in_next[0] = '{quad.red_top_left, quad.green_top_left, quad.blue_top_left};
        in_next[1] = '{quad.red_top_right, quad.green_top_right, quad.blue_top_right};
        in_next[2] = '{quad.red_bottom_left, quad.green_bottom_left,
                       quad.blue_bottom_left};
        in_next[3] = '{quad.red_bottom_right, quad.green_bottom_right,
                       quad.blue_bottom_right};
    end

    always_comb
    begin
        cb_sum = '0;
        cr_sum = '0;
        for (int i = 0; i < rq2y_pkg::Pixels; i++)
        begin
            cb_sum = cb_sum + {2'b00, pix_reg[i].cb};
            cr_sum = cr_sum + {2'b00, pix_reg[i].cr};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            pix_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= quad.valid;
            end
            if (pix_ready)
            begin
                pix_valid_reg <= in_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= pix_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && quad.valid)
        begin
            in_reg <= in_next;
        end
        if (pix_ready && in_valid_reg)
        begin
            for (int i = 0; i < rq2y_pkg::Pixels; i++)
            begin
                pix_reg[i] <= '{rq2y_pkg::luma_of(in_reg[i]),
                                rq2y_pkg::cb_of(in_reg[i]),
                                rq2y_pkg::cr_of(in_reg[i])};
            end
        end
        if (out_ready && pix_valid_reg)
        begin
            for (int i = 0; i < rq2y_pkg::Pixels; i++)
            begin
                luma_reg[i] <= pix_reg[i].luma;
            end
            cb_reg <= cb_sum[9:2];
            cr_reg <= cr_sum[9:2];
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.luma_top_left     = luma_reg[0];
    assign result.luma_top_right    = luma_reg[1];
    assign result.luma_bottom_left  = luma_reg[2];
    assign result.luma_bottom_right = luma_reg[3];
    assign result.blue_chroma       = cb_reg;
    assign result.red_chroma        = cr_reg;

endmodule

// ----- hdl/rq2y_checker.sv -----
// ----------------------------------------------------------------------------
// rq2y_checker: port-level checks for the quad converter
// Watches the channels of the top level and is bound to it below.
// ----------------------------------------------------------------------------
module rq2y_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input rq2y_pkg::chan_t luma_tl,
    input rq2y_pkg::chan_t luma_tr,
    input rq2y_pkg::chan_t luma_bl,
    input rq2y_pkg::chan_t luma_br,
    input rq2y_pkg::chan_t cb,
    input rq2y_pkg::chan_t cr
);

    // A result that is not taken stays presented with the same payload.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(luma_tl) && $stable(luma_tr)
            && $stable(luma_bl) && $stable(luma_br) && $stable(cb) && $stable(cr))
        else $error("stalled result changed");

    // The quad channel only backs up when a finished result is being held.
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("quad ready low without a stalled result");

    // Luma stays within the studio range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> luma_tl >= 8'd16 && luma_tl <= 8'd235
            && luma_tr >= 8'd16 && luma_tr <= 8'd235
            && luma_bl >= 8'd16 && luma_bl <= 8'd235
            && luma_br >= 8'd16 && luma_br <= 8'd235)
        else $error("luma out of range");

    // Chroma means stay within the range reachable from 8-bit inputs.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cb >= 8'd15 && cb <= 8'd240 && cr >= 8'd15 && cr <= 8'd240)
        else $error("chroma out of range");

    // A rising result needs an earlier accepted quad on the quad channel.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 3))
        else $error("result without a matching request");

endmodule

bind rgb_quad_to_ycbcr420_core rq2y_checker u_rq2y_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (quad.valid),
    .in_ready  (quad.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .luma_tl   (result.luma_top_left),
    .luma_tr   (result.luma_top_right),
    .luma_bl   (result.luma_bottom_left),
    .luma_br   (result.luma_bottom_right),
    .cb        (result.blue_chroma),
    .cr        (result.red_chroma)
);
